@@ hw/rtl/clamped_table_interpolator_defines.svh @@
// Assertion macros used by the checker file of the table interpolator.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef CLAMPED_TABLE_INTERPOLATOR_DEFINES_SVH
`define CLAMPED_TABLE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define CTI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cti assertion failed");

// Next-cycle implication, held off during reset.
`define CTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cti assertion failed");

`endif

@@ hw/rtl/cti_pkg.sv @@
// Shared constants for the clamped table interpolator.
// No dependencies; used by the top level and its checker.
package cti_pkg;

  localparam int MAX_POINTS_DEF = 32;

  localparam int MASS_W   = 32;
  localparam int YIELD_W  = 32;
  localparam int MARGIN_W = 18;
  localparam int COUNT_W  = 6;
  localparam int INDEX_W  = 5;
  localparam int CFG_W    = 18;

  localparam int FRAC_BITS = 16;
  localparam int FRAC_ONE  = 65536;
  // Factor magnitudes that matter stay below 2^20; larger ones always clamp.
  localparam int DIV_STEPS = 20;
  localparam int T_W       = 20;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic CFG_MARGIN = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef logic [MASS_W-1:0] mass_t;

endpackage

@@ hw/rtl/cti_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/clamped_table_interpolator.sv @@
// A write item leaves in_ready high. A query's result is formed after acceptance through
//   S = 0..n-1 mass compares of the linear search, one table read per cycle, and
//   D = 0 or 20 steps of the restoring divider (0 on equal masses or overflow).
// One query at a time; in_ready is low until its result enters the output register.
// Reset: synchronous, active low; clears control, margin = 0, point count = 2.
//   Table contents are not reset and must be written before they are read.
//
// Depends on cti_pkg and cti_ram.
module clamped_table_interpolator #(
  parameter int MAX_POINTS = cti_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [cti_pkg::CFG_W-1:0]         cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [cti_pkg::INDEX_W-1:0]       in_point_index,
  input  logic [cti_pkg::MASS_W-1:0]        in_point_mass,
  input  logic signed [cti_pkg::YIELD_W-1:0] in_point_yield,
  input  logic [cti_pkg::MASS_W-1:0]        in_query_mass,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cti_pkg::YIELD_W-1:0] out_interp_yield,
  output logic                              out_factor_clamped,
  output logic                              out_sign_suppressed
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int MW = cti_pkg::MASS_W;
  localparam int YW = cti_pkg::YIELD_W;
  localparam int TW = cti_pkg::T_W;
  localparam int PW = YW + 1 + TW;          // product width
  localparam int RW = PW - cti_pkg::FRAC_BITS; // rounded product width
  localparam int SW = RW + 1;               // final sum width

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LAST  = 4'd1;   // read mass[n-1]
  localparam logic [3:0] S_FIRST = 4'd2;   // read mass[0], catch mass[n-1]
  localparam logic [3:0] S_DEC   = 4'd3;   // pick edge case or start scan
  localparam logic [3:0] S_SCAN  = 4'd4;   // one compare per cycle
  localparam logic [3:0] S_FHI   = 4'd5;   // read upper point
  localparam logic [3:0] S_FLO   = 4'd6;   // read lower point, catch upper
  localparam logic [3:0] S_LOAD  = 4'd7;   // catch lower, form differences
  localparam logic [3:0] S_PREP  = 4'd8;   // magnitudes, divider setup
  localparam logic [3:0] S_DIV   = 4'd9;   // one quotient bit per cycle
  localparam logic [3:0] S_CLAMP = 4'd10;
  localparam logic [3:0] S_MUL   = 4'd11;
  localparam logic [3:0] S_SUM   = 4'd12;  // round, add, saturate, sign check

  logic [3:0] state_r, state_nxt;

  // configuration registers
  logic [cti_pkg::MARGIN_W-1:0] margin_r;
  logic [cti_pkg::COUNT_W-1:0]  count_r;

  // query context
  logic [MW-1:0]        q_r, q_nxt;
  logic [AW-1:0]        last_idx_r, last_idx_nxt;
  logic [MW-1:0]        last_m_r, last_m_nxt;
  logic [AW-1:0]        scan_r, scan_nxt;
  logic [AW-1:0]        top_r, top_nxt;
  logic [MW-1:0]        hi_m_r, hi_m_nxt;
  logic signed [YW-1:0] hi_y_r, hi_y_nxt;
  logic signed [YW-1:0] lo_y_r, lo_y_nxt;
  logic signed [MW:0]   num_r, num_nxt;
  logic signed [MW:0]   den_r, den_nxt;
  logic signed [YW:0]   ydiff_r, ydiff_nxt;

  // divider
  logic [MW-1:0]                 dmag_r, dmag_nxt;
  logic [MW-1:0]                 rem_r, rem_nxt;
  logic [cti_pkg::DIV_STEPS-1:0] dbits_r, dbits_nxt;
  logic [cti_pkg::DIV_STEPS-1:0] quo_r, quo_nxt;
  logic [$clog2(cti_pkg::DIV_STEPS)-1:0] cnt_r, cnt_nxt;
  logic                          neg_r, neg_nxt;
  logic                          ovf_r, ovf_nxt;

  logic signed [TW-1:0] t_r, t_nxt;
  logic                 clamp_r, clamp_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;

  // output register
  logic                 out_valid_r;
  logic signed [YW-1:0] out_yield_r;
  logic                 out_clamp_r;
  logic                 out_supp_r;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [MW-1:0] mass_rd;
  logic [YW-1:0] yield_rd;

  logic        in_fire;
  logic        out_load;
  logic [31:0] idx32;
  logic [31:0] cnt32;
  logic [31:0] last32;

  // combinational helpers
  logic [MW-1:0]  num_mag, den_mag;
  logic [MW+1:0]  trial;
  logic [TW-1:0]  lim_hi;
  logic [PW-1:0]  rsum;
  logic signed [RW-1:0] rnd;
  logic signed [SW-1:0] ysum;
  logic signed [YW-1:0] ysat;
  logic           ip, up, dn, supp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign out_valid           = out_valid_r;
  assign out_interp_yield    = out_yield_r;
  assign out_factor_clamped  = out_clamp_r;
  assign out_sign_suppressed = out_supp_r;

  // table writes: indexes past the table size are dropped
  assign idx32     = 32'(in_point_index);
  assign ram_we    = in_fire && (in_kind == cti_pkg::KIND_WRITE) && (idx32 < MAX_POINTS);
  assign ram_waddr = idx32[AW-1:0];

  cti_ram #(.WIDTH(MW), .DEPTH(MAX_POINTS)) u_mass_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_point_mass),
    .raddr (ram_raddr),
    .rdata (mass_rd)
  );

  cti_ram #(.WIDTH(YW), .DEPTH(MAX_POINTS)) u_yield_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_point_yield),
    .raddr (ram_raddr),
    .rdata (yield_rd)
  );

  // effective last index: count held to [2, MAX_POINTS]
  always_comb begin
    cnt32 = 32'(count_r);
    if (cnt32 < 32'd2) begin
      last32 = 32'd1;
    end else if (cnt32 > MAX_POINTS) begin
      last32 = 32'(MAX_POINTS - 1);
    end else begin
      last32 = cnt32 - 32'd1;
    end
  end

  // read address follows the sequencer; data shows in the following cycle
  always_comb begin
    case (state_r)
      S_LAST:  ram_raddr = last_idx_r;
      S_FIRST: ram_raddr = '0;
      S_DEC:   ram_raddr = AW'(1);
      S_SCAN:  ram_raddr = scan_r + AW'(1);
      S_FHI:   ram_raddr = top_r;
      S_FLO:   ram_raddr = top_r - AW'(1);
      default: ram_raddr = '0;
    endcase
  end

  // datapath pieces for the divider and the clamp
  assign num_mag = num_r[MW] ? MW'(-num_r) : num_r[MW-1:0];
  assign den_mag = den_r[MW] ? MW'(-den_r) : den_r[MW-1:0];
  assign trial   = {1'b0, rem_r, dbits_r[cti_pkg::DIV_STEPS-1]} - {2'b00, dmag_r};
  assign lim_hi  = TW'(cti_pkg::FRAC_ONE) + TW'(margin_r);

  // round half up, floor by 2^16, add lower yield, saturate
  assign rsum = prod_r + PW'(cti_pkg::FRAC_ONE / 2);
  assign rnd  = rsum[PW-1:cti_pkg::FRAC_BITS];
  assign ysum = SW'(lo_y_r) + SW'(rnd);

  always_comb begin
    if (ysum[SW-1:YW-1] == '0 || ysum[SW-1:YW-1] == '1) begin
      ysat = ysum[YW-1:0];
    end else if (ysum[SW-1]) begin
      ysat = {1'b1, {(YW-1){1'b0}}};
    end else begin
      ysat = {1'b0, {(YW-1){1'b1}}};
    end
    ip   = !ysat[YW-1] && (ysat != '0);
    up   = !lo_y_r[YW-1] && (lo_y_r != '0);
    dn   = !hi_y_r[YW-1] && (hi_y_r != '0);
    supp = (ip != up) && (ip != dn);
  end

  assign out_load = (state_r == S_SUM) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    q_nxt        = q_r;
    last_idx_nxt = last_idx_r;
    last_m_nxt   = last_m_r;
    scan_nxt     = scan_r;
    top_nxt      = top_r;
    hi_m_nxt     = hi_m_r;
    hi_y_nxt     = hi_y_r;
    lo_y_nxt     = lo_y_r;
    num_nxt      = num_r;
    den_nxt      = den_r;
    ydiff_nxt    = ydiff_r;
    dmag_nxt     = dmag_r;
    rem_nxt      = rem_r;
    dbits_nxt    = dbits_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    neg_nxt      = neg_r;
    ovf_nxt      = ovf_r;
    t_nxt        = t_r;
    clamp_nxt    = clamp_r;
    prod_nxt     = prod_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire && in_kind == cti_pkg::KIND_QUERY) begin
          q_nxt        = in_query_mass;
          last_idx_nxt = last32[AW-1:0];
          state_nxt    = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        last_m_nxt = mass_rd;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        // above last mass: final pair; at or below first: first pair
        if (q_r > last_m_r) begin
          top_nxt   = last_idx_r;
          state_nxt = S_FHI;
        end else if (q_r <= mass_rd) begin
          top_nxt   = AW'(1);
          state_nxt = S_FHI;
        end else begin
          scan_nxt  = AW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (mass_rd >= q_r || scan_r == last_idx_r) begin
          top_nxt   = scan_r;
          state_nxt = S_FHI;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      S_FHI: begin
        state_nxt = S_FLO;
      end
      S_FLO: begin
        hi_m_nxt  = mass_rd;
        hi_y_nxt  = yield_rd;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        lo_y_nxt  = yield_rd;
        num_nxt   = $signed({1'b0, q_r}) - $signed({1'b0, mass_rd});
        den_nxt   = $signed({1'b0, hi_m_r}) - $signed({1'b0, mass_rd});
        ydiff_nxt = $signed({hi_y_r[YW-1], hi_y_r}) - $signed({yield_rd[YW-1], yield_rd});
        state_nxt = S_PREP;
      end
      S_PREP: begin
        neg_nxt   = num_r[MW] ^ den_r[MW];
        dmag_nxt  = den_mag;
        rem_nxt   = MW'(num_mag >> 4);
        dbits_nxt = {num_mag[3:0], {cti_pkg::FRAC_BITS{1'b0}}};
        quo_nxt   = '0;
        cnt_nxt   = '0;
        // quotient of 2^20 or more lies past every clamp limit
        ovf_nxt   = ({4'b0000, num_mag} >= {den_mag, 4'b0000});
        if (den_r == '0) begin
          // equal masses: factor zero, no clamp
          t_nxt     = '0;
          clamp_nxt = 1'b0;
          state_nxt = S_MUL;
        end else if ({4'b0000, num_mag} >= {den_mag, 4'b0000}) begin
          state_nxt = S_CLAMP;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!trial[MW+1]) begin
          rem_nxt = trial[MW-1:0];
          quo_nxt = {quo_r[cti_pkg::DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[MW-2:0], dbits_r[cti_pkg::DIV_STEPS-1]};
          quo_nxt = {quo_r[cti_pkg::DIV_STEPS-2:0], 1'b0};
        end
        dbits_nxt = {dbits_r[cti_pkg::DIV_STEPS-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ($clog2(cti_pkg::DIV_STEPS))'(cti_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (!neg_r) begin
          if (ovf_r || quo_r > lim_hi) begin
            t_nxt     = lim_hi;
            clamp_nxt = 1'b1;
          end else begin
            t_nxt     = quo_r;
            clamp_nxt = 1'b0;
          end
        end else begin
          if (ovf_r || quo_r > TW'(margin_r)) begin
            t_nxt     = -$signed(TW'(margin_r));
            clamp_nxt = 1'b1;
          end else begin
            t_nxt     = -$signed(quo_r);
            clamp_nxt = 1'b0;
          end
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = ydiff_r * t_r;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // waits here while an earlier result is still unclaimed
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      margin_r    <= '0;
      count_r     <= cti_pkg::COUNT_W'(2);
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cti_pkg::CFG_MARGIN) begin
          margin_r <= cfg_data[cti_pkg::MARGIN_W-1:0];
        end else begin
          count_r <= cfg_data[cti_pkg::COUNT_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    last_idx_r <= last_idx_nxt;
    last_m_r   <= last_m_nxt;
    scan_r     <= scan_nxt;
    top_r      <= top_nxt;
    hi_m_r     <= hi_m_nxt;
    hi_y_r     <= hi_y_nxt;
    lo_y_r     <= lo_y_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    ydiff_r    <= ydiff_nxt;
    dmag_r     <= dmag_nxt;
    rem_r      <= rem_nxt;
    dbits_r    <= dbits_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    ovf_r      <= ovf_nxt;
    t_r        <= t_nxt;
    clamp_r    <= clamp_nxt;
    prod_r     <= prod_nxt;
    if (out_load) begin
      out_yield_r <= supp ? '0 : ysat;
      out_clamp_r <= clamp_r;
      out_supp_r  <= supp;
    end
  end

endmodule

@@ hw/rtl/cti_checker.sv @@
// Port-level checks for the clamped table interpolator, bound to the top level.
// Depends on cti_pkg and clamped_table_interpolator_defines.svh.
`include "clamped_table_interpolator_defines.svh"

module cti_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_kind,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cti_pkg::YIELD_W-1:0] out_interp_yield,
  input logic                              out_factor_clamped,
  input logic                              out_sign_suppressed
);

  // a query holds the block busy for the next cycle
  `CTI_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_kind == cti_pkg::KIND_QUERY, !in_ready)
  // a table write never stalls the input
  `CTI_ASSERT_NEXT(a_write_ready, in_valid && in_ready && in_kind == cti_pkg::KIND_WRITE, in_ready)
  // a suppressed result is zero
  `CTI_ASSERT_NOW(a_supp_zero, out_valid && out_sign_suppressed, out_interp_yield == '0)
  // a waiting item holds
  `CTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_interp_yield) && $stable(out_factor_clamped))

endmodule

bind clamped_table_interpolator cti_checker u_cti_checker (.*);
